// File: hw/rtl/stable_priority_queue_core_assert.svh
// Assertion macros for the stable priority queue core.
// Used by the checker; expects clk_i and rst_ni in scope.
`ifndef STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spq assertion failed");

`endif

// File: hw/rtl/spq_pkg.sv
// Package for the stable priority queue: opcodes, status codes, defaults
// and the cell command struct. No dependencies.
package spq_pkg;

  localparam int unsigned CapacityDef     = 16;
  localparam int unsigned PriorityBitsDef = 8;
  localparam int unsigned ValueBits       = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic push;
    logic pop;
  } spq_cmd_t;

endpackage

// File: hw/rtl/spq_cell.sv
// One slot of the sorted row: holds a value and priority, and shifts
// right on insert or left on pop. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef,
  parameter int unsigned CNT_W         = 5
) (
  input  logic                        clk_i,
  input  spq_cmd_t                    cmd_i,
  input  logic [CNT_W-1:0]            count_i,
  input  logic signed [ValueBits-1:0] new_value_i,
  input  logic [PRIORITY_BITS-1:0]    new_prio_i,
  input  logic                        left_keep_i,
  input  logic signed [ValueBits-1:0] left_value_i,
  input  logic [PRIORITY_BITS-1:0]    left_prio_i,
  input  logic signed [ValueBits-1:0] right_value_i,
  input  logic [PRIORITY_BITS-1:0]    right_prio_i,
  output logic                        keep_o,
  output logic signed [ValueBits-1:0] value_o,
  output logic [PRIORITY_BITS-1:0]    prio_o
);

  logic signed [ValueBits-1:0] value_q, value_d;
  logic [PRIORITY_BITS-1:0]    prio_q, prio_d;
  logic                        occ;

  assign occ    = CNT_W'(IDX) < count_i;
  // occupied and not more urgent-blocking: the new entry goes after this one
  assign keep_o = occ && (prio_q <= new_prio_i);

  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.push) begin
      if (!left_keep_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (!keep_o) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (cmd_i.pop) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// File: hw/rtl/stable_priority_queue_core.sv
// Stable priority queue top level: a row of spq_cell slots plus count,
// status and output registers. Depends on spq_pkg and spq_cell.
//
// Takes one request per cycle: a push, pop or status read updates the whole
// row of cells in the cycle it is accepted, and its result is registered in a
// pending stage and then in the output register. Throughput is one request
// per cycle, set by the cell row shifting as each request is accepted.
// Requests are held off only while a result waits behind a stalled output.
module stable_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned CAPACITY      = CapacityDef,
  parameter int unsigned PRIORITY_BITS = PriorityBitsDef,
  localparam int unsigned CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic signed [ValueBits-1:0] item_value_i,
  input  logic [PRIORITY_BITS-1:0]    item_priority_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [ValueBits-1:0] front_value_o,
  output logic signed [ValueBits-1:0] back_value_o,
  output logic [CNT_W-1:0]            entry_count_o,
  output logic                        is_empty_o,
  output logic [1:0]                  status_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  status_e          pstat_q, pstat_d;
  logic             ovld_q, ovld_d;
  logic signed [ValueBits-1:0] front_q, back_q;
  logic [CNT_W-1:0] ocnt_q;
  logic             oempty_q;
  status_e          ostat_q;

  logic in_acc, move, is_push, is_pop, full, empty;
  spq_cmd_t cmd;
  logic signed [ValueBits-1:0] front_sel, back_sel;

  logic                        keep  [CAPACITY];
  logic signed [ValueBits-1:0] c_val [CAPACITY];
  logic [PRIORITY_BITS-1:0]    c_prio[CAPACITY];

  assign move       = pend_q && (!ovld_q || !out_stall_i);
  assign in_stall_o = pend_q && !move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign full     = count_q == CNT_W'(CAPACITY);
  assign empty    = count_q == '0;
  assign is_push  = opcode_i == OP_PUSH;
  assign is_pop   = opcode_i == OP_POP;
  assign cmd.push = in_acc && is_push && !full;
  assign cmd.pop  = in_acc && is_pop && !empty;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                        lk;
    logic signed [ValueBits-1:0] lv, rv;
    logic [PRIORITY_BITS-1:0]    lp, rp;
    if (g == 0) begin : g_first
      assign lk = 1'b1;
      assign lv = c_val[g];
      assign lp = c_prio[g];
    end else begin : g_mid
      assign lk = keep[g-1];
      assign lv = c_val[g-1];
      assign lp = c_prio[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rv = c_val[g];
      assign rp = c_prio[g];
    end else begin : g_inner
      assign rv = c_val[g+1];
      assign rp = c_prio[g+1];
    end
    spq_cell #(
      .IDX          (g),
      .PRIORITY_BITS(PRIORITY_BITS),
      .CNT_W        (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .new_value_i  (item_value_i),
      .new_prio_i   (item_priority_i),
      .left_keep_i  (lk),
      .left_value_i (lv),
      .left_prio_i  (lp),
      .right_value_i(rv),
      .right_prio_i (rp),
      .keep_o       (keep[g]),
      .value_o      (c_val[g]),
      .prio_o       (c_prio[g])
    );
  end

  always_comb begin
    count_d = count_q;
    pstat_d = pstat_q;
    pend_d  = move ? 1'b0 : pend_q;
    if (cmd.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.pop) begin
      count_d = count_q - CNT_W'(1);
    end
    if (in_acc) begin
      pend_d = 1'b1;
      if (is_push && full) begin
        pstat_d = ST_PUSH_FULL;
      end else if (is_pop && empty) begin
        pstat_d = ST_POP_EMPTY;
      end else begin
        pstat_d = ST_OK;
      end
    end
  end

  // last entry is the one-hot cell at count - 1
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i + 1) == count_q) begin
        back_sel = back_sel | c_val[i];
      end
    end
    front_sel = empty ? '0 : c_val[0];
  end

  assign ovld_d = move || (ovld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      pstat_q <= ST_OK;
      ovld_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      pstat_q <= pstat_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      front_q  <= front_sel;
      back_q   <= back_sel;
      ocnt_q   <= count_q;
      oempty_q <= empty;
      ostat_q  <= pstat_q;
    end
  end

  assign out_valid_o   = ovld_q;
  assign front_value_o = front_q;
  assign back_value_o  = back_q;
  assign entry_count_o = ocnt_q;
  assign is_empty_o    = oempty_q;
  assign status_o      = ostat_q;

endmodule

// File: hw/rtl/spq_checker.sv
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue_core_assert.svh.
`include "stable_priority_queue_core_assert.svh"

module spq_checker import spq_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [ValueBits-1:0] front_value_o,
  input logic signed [ValueBits-1:0] back_value_o,
  input logic [CNT_W-1:0]            entry_count_o,
  input logic                        is_empty_o,
  input logic [1:0]                  status_o
);

  `SPQ_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `SPQ_ASSERT_IMP(a_empty_flag, out_valid_o, is_empty_o == (entry_count_o == '0))
  `SPQ_ASSERT_IMP(a_empty_zero, out_valid_o && is_empty_o,
                  front_value_o == '0 && back_value_o == '0)
  `SPQ_ASSERT_IMP(a_full_drop, out_valid_o && status_o == ST_PUSH_FULL,
                  entry_count_o == CNT_W'(CAPACITY))

endmodule

bind stable_priority_queue_core spq_checker #(
  .CAPACITY(CAPACITY)
) u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .front_value_o(front_value_o),
  .back_value_o (back_value_o),
  .entry_count_o(entry_count_o),
  .is_empty_o   (is_empty_o),
  .status_o     (status_o)
);
